### src/gif_pkg.sv
// ----------------------------------------------------------------------------
// gif_pkg: shared definitions of the gray guided filter
// Widths, state and operation codes and the request and response bundles
// of the serial multiplier and divider.
// ----------------------------------------------------------------------------
`default_nettype none

package gif_pkg;

  localparam int unsigned COL_W    = 10;  // column index, MAX_WIDTH = 1024
  localparam int unsigned SLOT_W   = 5;   // line slot index, LINE_SLOTS = 32
  localparam int unsigned ADDR_W   = SLOT_W + COL_W;
  localparam int unsigned DEPTH    = 1 << ADDR_W;
  localparam int unsigned PIX_W    = 24;  // guide and source packed together
  localparam int unsigned DIM_W    = 11;
  localparam int unsigned MAX_W    = 1024;
  localparam int unsigned MIN_DIM  = 16;

  localparam int unsigned MUL_A_W  = 72;
  localparam int unsigned MUL_B_W  = 32;
  localparam int unsigned DIV_W    = 72;
  localparam int unsigned DVS_W    = 56;
  localparam int unsigned CNT_W    = 7;

  localparam logic [7:0] REG_RADIUS = 8'd0;
  localparam logic [7:0] REG_EPS    = 8'd1;
  localparam logic [7:0] REG_WIDTH  = 8'd2;
  localparam logic [7:0] REG_HEIGHT = 8'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WIN,
    ST_DRAIN,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NSII,
    OP_SISI,
    OP_NN,
    OP_NNREG,
    OP_NSIP,
    OP_SISP,
    OP_ICEN,
    OP_DD,
    OP_T,
    OP_TERM
  } op_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_A_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DVS_W-1:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

### src/gif_if.sv
// ----------------------------------------------------------------------------
// gif_if: channel interfaces of the gray guided filter
// Pixel input, filtered output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface gif_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  guide_pixel;
  logic [15:0] source_sample;
  modport source (output valid, kind, guide_pixel, source_sample, input ready);
  modport sink (input valid, kind, guide_pixel, source_sample, output ready);
endinterface

interface gif_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered_sample;
  logic        saturated;
  logic        frame_last;
  modport source (output valid, filtered_sample, saturated, frame_last, input ready);
  modport sink (input valid, filtered_sample, saturated, frame_last, output ready);
endinterface

interface gif_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/guided_image_filter_core.sv
// ----------------------------------------------------------------------------
// guided_image_filter_core: gray guided filter over a raster pixel stream
// Line store, window accumulation and a sequenced multiply/divide datapath.
// ----------------------------------------------------------------------------
// Items enter on in_i: a pixel pair (kind 0) or a flush tick (kind 1). Each
// accepted frame pixel is written into the line store, and each item, once the
// window of the next output pixel is fully received, produces one filtered item on
// out_o; otherwise it produces nothing. Output lags input by r rows plus r
// pixels, and flush ticks drain the tail of the frame.
// The block takes one item at a time. An item with a result walks the window
// taps (one line store read per cycle), runs up to ten serial multiplies on
// the shared shift-add unit, then the restoring divider unless a negative
// result is settled without it, and last loads the output register.
// The result waits in the output register while the next item is taken; a
// stalled receiver only holds the block when a second result is finished.
// Writes on cfg_i are always accepted, and register writes restart the
// frame. They must be issued only while the block is idle; it does not check.
// Reset sets the registers to radius 7, eps 256, 640 by 480 and clears the
// frame counters. The line store needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module guided_image_filter_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gif_in_if.sink    in_i,
  gif_out_if.source out_o,
  gif_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [3:0]  radius_q;
  logic [23:0] eps_q;
  logic [10:0] fwidth_q;
  logic [10:0] fheight_q;

  gif_pkg::state_e state_q, state_d;
  gif_pkg::op_e    op_q;
  logic            issued_q;

  // Frame position counters.
  logic [9:0]  in_col_q;
  logic [10:0] in_row_q;
  logic [9:0]  out_x_q;
  logic [10:0] out_y_q;

  // Window walk.
  logic signed [5:0] dy_q, dx_q;
  logic              rv_q, rc_q;
  logic [17:0]       si_q;
  logic [25:0]       sp_q;
  logic [33:0]       sip_q;
  logic [25:0]       sii_q;
  logic [7:0]        gc_q;

  // Datapath intermediates.
  logic [71:0] tmp_q;
  logic [35:0] var_q;
  logic [44:0] den_q;
  logic [51:0] mag_a_q;
  logic        neg_a_q;
  logic [17:0] mag_d_q;
  logic        neg_d_q;
  logic [54:0] dd_q;
  logic [71:0] t_q;
  logic [71:0] num_q;
  logic [55:0] dvs_q;
  logic [15:0] res_q;
  logic        rsat_q;

  // Output register.
  logic        out_valid_q;
  logic [15:0] out_sample_q;
  logic        out_sat_q;
  logic        out_last_q;

  gif_pkg::mul_req_t mul_req;
  gif_pkg::mul_rsp_t mul_rsp;
  gif_pkg::div_req_t div_req;
  gif_pkg::div_rsp_t div_rsp;

  logic                       ram_we;
  logic [gif_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [gif_pkg::PIX_W-1:0]  ram_rdata;

  // Effective frame geometry; the radius never exceeds the slot limit.
  logic [10:0] eff_w, eff_h;
  logic [4:0]  side;
  logic [9:0]  npix;

  always_comb begin
    if (fwidth_q < 11'(gif_pkg::MIN_DIM)) begin
      eff_w = 11'(gif_pkg::MIN_DIM);
    end else if (fwidth_q > 11'(gif_pkg::MAX_W)) begin
      eff_w = 11'(gif_pkg::MAX_W);
    end else begin
      eff_w = fwidth_q;
    end
    eff_h = (fheight_q < 11'(gif_pkg::MIN_DIM)) ? 11'(gif_pkg::MIN_DIM) : fheight_q;
  end

  assign side = {radius_q, 1'b1};
  assign npix = 10'(side * side);

  // Reflect-101 mirroring of an index that lies within one radius of the frame.
  function automatic logic [10:0] reflect(logic signed [12:0] k, logic [10:0] len);
    logic signed [12:0] l;
    logic signed [12:0] t;
    l = $signed({2'b00, len});
    t = ((l - 13'sd1) <<< 1) - k;
    if (k < 13'sd0) begin
      return 11'(-k);
    end else if (k >= l) begin
      return t[10:0];
    end else begin
      return k[10:0];
    end
  endfunction

  logic [10:0] tap_row, tap_col;
  logic        in_accept, complete, px_ready, tap_last, frame_end;
  logic [10:0] need_y;
  logic [9:0]  need_x;
  logic signed [5:0] rad_s;

  assign rad_s     = $signed({2'b00, radius_q});
  assign tap_row   = reflect($signed({2'b00, out_y_q}) + 13'(dy_q), eff_h);
  assign tap_col   = reflect($signed({3'b000, out_x_q}) + 13'(dx_q), eff_w);
  assign tap_last  = (dx_q == rad_s) && (dy_q == rad_s);
  assign in_accept = in_i.valid && in_i.ready;
  assign complete  = in_row_q >= eff_h;
  assign frame_end = ({1'b0, out_x_q} == eff_w - 11'd1) && (out_y_q == eff_h - 11'd1);

  always_comb begin
    need_y = ({1'b0, out_y_q} + 12'(radius_q) < {1'b0, eff_h} - 12'd1)
             ? out_y_q + 11'(radius_q) : eff_h - 11'd1;
    need_x = ({1'b0, out_x_q} + 11'(radius_q) < eff_w - 11'd1)
             ? out_x_q + 10'(radius_q) : 10'(eff_w - 11'd1);
    px_ready = complete || (in_row_q > need_y) ||
               ((in_row_q == need_y) && (in_col_q > need_x));
  end

  // Combinations of the multiplier result with the stored terms.
  logic [44:0] den_next;
  logic [71:0] half, sum_same, sum_diff, deficit;
  logic        t_lt;
  logic [43:0] a_diff;
  logic [17:0] icen;

  assign den_next = {var_q, 8'd0} + mul_rsp.p[44:0];
  assign half     = {18'd0, dd_q[54:1]};
  assign sum_same = t_q + mul_rsp.p + half;
  assign sum_diff = t_q - mul_rsp.p + half;
  assign t_lt     = t_q < mul_rsp.p;
  assign deficit  = mul_rsp.p - t_q;
  assign a_diff   = (tmp_q[43:0] < mul_rsp.p[43:0]) ? mul_rsp.p[43:0] - tmp_q[43:0]
                                                    : tmp_q[43:0] - mul_rsp.p[43:0];
  assign icen     = mul_rsp.p[17:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gif_pkg::ST_IDLE: begin
        if (in_accept) state_d = gif_pkg::ST_CHECK;
      end
      gif_pkg::ST_CHECK: begin
        state_d = px_ready ? gif_pkg::ST_WIN : gif_pkg::ST_IDLE;
      end
      gif_pkg::ST_WIN: begin
        if (tap_last) state_d = gif_pkg::ST_DRAIN;
      end
      gif_pkg::ST_DRAIN: begin
        state_d = gif_pkg::ST_MUL;
      end
      gif_pkg::ST_MUL: begin
        if (issued_q && mul_rsp.done) begin
          if (op_q == gif_pkg::OP_NNREG && den_next == '0) begin
            state_d = gif_pkg::ST_DIV;
          end else if (op_q == gif_pkg::OP_TERM) begin
            state_d = (neg_a_q != neg_d_q && t_lt) ? gif_pkg::ST_OUT : gif_pkg::ST_DIV;
          end
        end
      end
      gif_pkg::ST_DIV: begin
        if (issued_q && div_rsp.done) state_d = gif_pkg::ST_OUT;
      end
      gif_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) state_d = gif_pkg::ST_IDLE;
      end
      default: state_d = gif_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_i.ready    = (state_q == gif_pkg::ST_IDLE);
    cfg_i.ready   = 1'b1;
    ram_we        = in_accept && !in_i.kind && !complete;
    ram_waddr     = {in_row_q[gif_pkg::SLOT_W-1:0], in_col_q};
    ram_raddr     = {tap_row[gif_pkg::SLOT_W-1:0], tap_col[gif_pkg::COL_W-1:0]};
    mul_req.start = (state_q == gif_pkg::ST_MUL) && !issued_q;
    div_req.start = (state_q == gif_pkg::ST_DIV) && !issued_q;
    div_req.num   = num_q;
    div_req.dvs   = dvs_q;
    mul_req.a     = '0;
    mul_req.b     = '0;
    case (op_q)
      gif_pkg::OP_NSII:  begin mul_req.a = 72'(sii_q);   mul_req.b = 32'(npix);  end
      gif_pkg::OP_SISI:  begin mul_req.a = 72'(si_q);    mul_req.b = 32'(si_q);  end
      gif_pkg::OP_NN:    begin mul_req.a = 72'(npix);    mul_req.b = 32'(npix);  end
      gif_pkg::OP_NNREG: begin mul_req.a = tmp_q;        mul_req.b = 32'(eps_q); end
      gif_pkg::OP_NSIP:  begin mul_req.a = 72'(sip_q);   mul_req.b = 32'(npix);  end
      gif_pkg::OP_SISP:  begin mul_req.a = 72'(sp_q);    mul_req.b = 32'(si_q);  end
      gif_pkg::OP_ICEN:  begin mul_req.a = 72'(gc_q);    mul_req.b = 32'(npix);  end
      gif_pkg::OP_DD:    begin mul_req.a = 72'(den_q);   mul_req.b = 32'(npix);  end
      gif_pkg::OP_T:     begin mul_req.a = 72'(den_q);   mul_req.b = 32'(sp_q);  end
      gif_pkg::OP_TERM:  begin mul_req.a = 72'(mag_a_q); mul_req.b = 32'(mag_d_q); end
      default:           begin mul_req.a = '0;           mul_req.b = '0;         end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gif_pkg::ST_IDLE;
      op_q        <= gif_pkg::OP_NSII;
      issued_q    <= 1'b0;
      radius_q    <= 4'd7;
      eps_q       <= 24'd256;
      fwidth_q    <= 11'd640;
      fheight_q   <= 11'd480;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == gif_pkg::ST_WIN);

      if (mul_req.start || div_req.start) begin
        issued_q <= 1'b1;
      end else if ((state_q == gif_pkg::ST_MUL && mul_rsp.done) ||
                   (state_q == gif_pkg::ST_DIV && div_rsp.done)) begin
        issued_q <= 1'b0;
      end

      if (state_q == gif_pkg::ST_DRAIN) begin
        op_q <= gif_pkg::OP_NSII;
      end else if (state_q == gif_pkg::ST_MUL && issued_q && mul_rsp.done) begin
        case (op_q)
          gif_pkg::OP_NSII:  op_q <= gif_pkg::OP_SISI;
          gif_pkg::OP_SISI:  op_q <= gif_pkg::OP_NN;
          gif_pkg::OP_NN:    op_q <= gif_pkg::OP_NNREG;
          gif_pkg::OP_NNREG: op_q <= gif_pkg::OP_NSIP;
          gif_pkg::OP_NSIP:  op_q <= gif_pkg::OP_SISP;
          gif_pkg::OP_SISP:  op_q <= gif_pkg::OP_ICEN;
          gif_pkg::OP_ICEN:  op_q <= gif_pkg::OP_DD;
          gif_pkg::OP_DD:    op_q <= gif_pkg::OP_T;
          gif_pkg::OP_T:     op_q <= gif_pkg::OP_TERM;
          default:           op_q <= gif_pkg::OP_NSII;
        endcase
      end

      // A pixel arriving after the whole frame is in acts as a flush tick.
      if (ram_we) begin
        if ({1'b0, in_col_q} + 11'd1 >= eff_w) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 11'd1;
        end else begin
          in_col_q <= in_col_q + 10'd1;
        end
      end

      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == gif_pkg::ST_OUT && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
        if (frame_end) begin
          out_x_q  <= '0;
          out_y_q  <= '0;
          in_col_q <= '0;
          in_row_q <= '0;
        end else if ({1'b0, out_x_q} + 11'd1 == eff_w) begin
          out_x_q <= '0;
          out_y_q <= out_y_q + 11'd1;
        end else begin
          out_x_q <= out_x_q + 10'd1;
        end
      end

      // Any register write restarts the frame.
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          gif_pkg::REG_RADIUS: radius_q  <= cfg_i.data[3:0];
          gif_pkg::REG_EPS:    eps_q     <= cfg_i.data;
          gif_pkg::REG_WIDTH:  fwidth_q  <= cfg_i.data[10:0];
          gif_pkg::REG_HEIGHT: fheight_q <= cfg_i.data[10:0];
          default: ;
        endcase
        if (cfg_i.index <= gif_pkg::REG_HEIGHT) begin
          in_col_q <= '0;
          in_row_q <= '0;
          out_x_q  <= '0;
          out_y_q  <= '0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rc_q <= (dx_q == 6'sd0) && (dy_q == 6'sd0);

    if (state_q == gif_pkg::ST_CHECK) begin
      dy_q  <= -rad_s;
      dx_q  <= -rad_s;
      si_q  <= '0;
      sp_q  <= '0;
      sip_q <= '0;
      sii_q <= '0;
    end else if (state_q == gif_pkg::ST_WIN) begin
      if (dx_q == rad_s) begin
        dx_q <= -rad_s;
        dy_q <= dy_q + 6'sd1;
      end else begin
        dx_q <= dx_q + 6'sd1;
      end
    end

    if (rv_q) begin
      si_q  <= si_q + 18'(ram_rdata[23:16]);
      sp_q  <= sp_q + 26'(ram_rdata[15:0]);
      sip_q <= sip_q + 34'(ram_rdata[23:16] * ram_rdata[15:0]);
      sii_q <= sii_q + 26'(ram_rdata[23:16] * ram_rdata[23:16]);
      if (rc_q) gc_q <= ram_rdata[23:16];
    end

    if (state_q == gif_pkg::ST_MUL && issued_q && mul_rsp.done) begin
      case (op_q)
        gif_pkg::OP_NSII: tmp_q <= mul_rsp.p;
        gif_pkg::OP_SISI: begin
          var_q <= (tmp_q[35:0] > mul_rsp.p[35:0]) ? tmp_q[35:0] - mul_rsp.p[35:0] : '0;
        end
        gif_pkg::OP_NN: tmp_q <= mul_rsp.p;
        gif_pkg::OP_NNREG: begin
          den_q <= den_next;
          // Flat window with no regularizer: the plain rounded mean of p.
          num_q <= 72'(sp_q) + 72'(npix[9:1]);
          dvs_q <= 56'(npix);
        end
        gif_pkg::OP_NSIP: tmp_q <= mul_rsp.p;
        gif_pkg::OP_SISP: begin
          neg_a_q <= tmp_q[43:0] < mul_rsp.p[43:0];
          mag_a_q <= {a_diff, 8'd0};
        end
        gif_pkg::OP_ICEN: begin
          neg_d_q <= icen < si_q;
          mag_d_q <= (icen < si_q) ? si_q - icen : icen - si_q;
        end
        gif_pkg::OP_DD: dd_q <= mul_rsp.p[54:0];
        gif_pkg::OP_T:  t_q  <= mul_rsp.p;
        gif_pkg::OP_TERM: begin
          dvs_q <= {1'b0, dd_q};
          if (neg_a_q == neg_d_q) begin
            num_q <= sum_same;
          end else if (t_lt) begin
            // Negative q: rounds to zero within half a step, else clamps.
            res_q  <= '0;
            rsat_q <= deficit > half;
          end else begin
            num_q <= sum_diff;
          end
        end
        default: ;
      endcase
    end

    if (state_q == gif_pkg::ST_DIV && issued_q && div_rsp.done) begin
      if (div_rsp.quo > 72'd65535) begin
        res_q  <= 16'hFFFF;
        rsat_q <= 1'b1;
      end else begin
        res_q  <= div_rsp.quo[15:0];
        rsat_q <= 1'b0;
      end
    end

    if (state_q == gif_pkg::ST_OUT && (!out_valid_q || out_o.ready)) begin
      out_sample_q <= res_q;
      out_sat_q    <= rsat_q;
      out_last_q   <= frame_end;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_sample_q;
  assign out_o.saturated       = out_sat_q;
  assign out_o.frame_last      = out_last_q;

  gif_ram #(
    .WIDTH(gif_pkg::PIX_W),
    .DEPTH(gif_pkg::DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({in_i.guide_pixel, in_i.source_sample}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  gif_mul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  gif_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

endmodule

`default_nettype wire

### src/gif_ram.sv
// ----------------------------------------------------------------------------
// gif_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### src/gif_mul.sv
// ----------------------------------------------------------------------------
// gif_mul: shared shift-and-add multiplier
// Consumes one multiplier bit per cycle and stops when none are left.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gif_pkg::mul_req_t req_i,
  output gif_pkg::mul_rsp_t      rsp_o
);

  logic                        busy_q;
  logic [gif_pkg::MUL_A_W-1:0] a_q;
  logic [gif_pkg::MUL_B_W-1:0] b_q;
  logic [gif_pkg::MUL_A_W-1:0] acc_q;
  logic                        done;

  assign done = busy_q && (b_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q && !done) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[gif_pkg::MUL_A_W-2:0], 1'b0};
      b_q <= {1'b0, b_q[gif_pkg::MUL_B_W-1:1]};
    end
  end

  assign rsp_o.done = done;
  assign rsp_o.p    = acc_q;

endmodule

`default_nettype wire

### src/gif_div.sv
// ----------------------------------------------------------------------------
// gif_div: shared restoring divider
// Produces one quotient bit per cycle over the full numerator width.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gif_pkg::div_req_t req_i,
  output gif_pkg::div_rsp_t      rsp_o
);

  logic                        busy_q;
  logic [gif_pkg::CNT_W-1:0]   cnt_q;
  logic [gif_pkg::DIV_W-1:0]   num_q;
  logic [gif_pkg::DVS_W-1:0]   dvs_q;
  logic [gif_pkg::DVS_W:0]     rem_q;
  logic [gif_pkg::DVS_W:0]     trial;
  logic                        done;

  assign done  = busy_q && (cnt_q == gif_pkg::CNT_W'(gif_pkg::DIV_W));
  assign trial = {rem_q[gif_pkg::DVS_W-1:0], num_q[gif_pkg::DIV_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      dvs_q <= req_i.dvs;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (busy_q && !done) begin
      cnt_q <= cnt_q + 1'b1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_q <= trial - {1'b0, dvs_q};
        num_q <= {num_q[gif_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        num_q <= {num_q[gif_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done;
  assign rsp_o.quo  = num_q;

endmodule

`default_nettype wire

### bench/guided_image_filter_core_tb.sv
// ----------------------------------------------------------------------------
// guided_image_filter_core_tb: self-checking bench of the gray guided filter
// Streams frames of guide and source pixels through the core under several
// register settings, predicts every filtered item with an exact integer
// model of the filter and compares each output item field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module guided_image_filter_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS     = 32;
  localparam int unsigned STORE_LEN = SLOTS * gif_pkg::MAX_W;
  localparam int unsigned RADIUS_CAP = 15;

  // Content styles of a generated frame.
  typedef enum int {
    PAT_RANDOM,
    PAT_FLAT,
    PAT_NEAR_FLAT,
    PAT_EXTREME,
    PAT_RAMP
  } pattern_e;

  typedef struct {
    logic        kind;
    logic [7:0]  guide;
    logic [15:0] source;
  } pixel_item_t;

  typedef struct {
    logic [15:0] sample;
    logic        sat;
    logic        last;
  } filtered_t;

  logic clk_i;
  logic rst_ni;

  gif_in_if  in_ch ();
  gif_out_if out_ch ();
  gif_cfg_if cfg_ch ();

  guided_image_filter_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // Items waiting to be offered, and filtered items the core still owes us.
  pixel_item_t pending_items[$];
  filtered_t   owed_samples[$];
  pixel_item_t offered;

  // Shadow of the core: registers, frame counters and both line stores.
  logic [3:0]  sh_radius;
  logic [23:0] sh_eps;
  logic [10:0] sh_width;
  logic [10:0] sh_height;
  int unsigned in_col, in_row, out_pos;
  logic [7:0]  guide_store  [STORE_LEN];
  logic [15:0] source_store [STORE_LEN];

  // Run bookkeeping.
  int unsigned errors;
  int unsigned accepted_cnt;
  int unsigned sample_cnt, sat_cnt, frame_cnt;
  bit          calm;
  bit          hold_done;
  int unsigned hold_left;

  initial begin
    clk_i  = 1'b0;
    rst_ni = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // A hard ceiling on the run; a correct run finishes far earlier.
  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned used_width();
    if (sh_width < gif_pkg::MIN_DIM) return gif_pkg::MIN_DIM;
    if (sh_width > gif_pkg::MAX_W) return gif_pkg::MAX_W;
    return sh_width;
  endfunction

  function automatic int unsigned used_height();
    return (sh_height < gif_pkg::MIN_DIM) ? gif_pkg::MIN_DIM : sh_height;
  endfunction

  function automatic int unsigned used_radius(int unsigned w);
    int unsigned r;
    r = sh_radius;
    if (r > RADIUS_CAP) r = RADIUS_CAP;
    if (r > w - 1) r = w - 1;
    return r;
  endfunction

  // Reflect-101 border: index -k maps to k, len-1+k maps to len-1-k.
  function automatic int reflect(int k, int len);
    int period, m;
    if (len <= 1) return 0;
    period = 2 * (len - 1);
    m = k % period;
    if (m < 0) m += period;
    if (m >= len) m = period - m;
    return m;
  endfunction

  function automatic int unsigned store_addr(int unsigned row, int unsigned col);
    return (row % SLOTS) * gif_pkg::MAX_W + (col % gif_pkg::MAX_W);
  endfunction

  // Exact guided filter for the pixel at (x, y), rounded to nearest, ties up.
  function automatic filtered_t filter_pixel(int x, int y, int w, int h, int r);
    logic signed [159:0] si, sp, sip, sii, n, var_i, den, dd, t, g, s;
    filtered_t res;
    int rr, cc;
    si = 0; sp = 0; sip = 0; sii = 0;
    res.sat = 1'b0;
    res.last = 1'b0;
    for (int dy = -r; dy <= r; dy++) begin
      rr = reflect(y + dy, h);
      for (int dx = -r; dx <= r; dx++) begin
        cc = reflect(x + dx, w);
        g = guide_store[store_addr(rr, cc)];
        s = source_store[store_addr(rr, cc)];
        si += g;
        sp += s;
        sip += g * s;
        sii += g * g;
      end
    end
    n = (2 * r + 1) * (2 * r + 1);
    var_i = n * sii - si * si;
    if (var_i < 0) var_i = 0;
    den = 256 * var_i + n * n * sh_eps;
    if (den == 0) begin
      // Flat window with no regularizer: the slope is taken as zero.
      t = (sp + n / 2) / n;
      res.sample = t[15:0];
      return res;
    end
    dd = n * den;
    g = guide_store[store_addr(y, x)];
    t = sp * den + 256 * (n * sip - si * sp) * (n * g - si);
    if (t < 0) begin
      res.sample = 16'd0;
      res.sat = (-t > dd / 2);
      return res;
    end
    t = (t + dd / 2) / dd;
    if (t > 65535) begin
      res.sample = 16'hFFFF;
      res.sat = 1'b1;
    end else begin
      res.sample = t[15:0];
    end
    return res;
  endfunction

  // Advances the shadow by one accepted item and queues any result it owes.
  function automatic void advance_filter(pixel_item_t it);
    int unsigned w, h, r, total, x, y, received, need;
    bit complete;
    filtered_t res;
    w = used_width();
    h = used_height();
    r = used_radius(w);
    total = w * h;
    complete = (in_row >= h);
    if (it.kind == 1'b0 && !complete) begin
      guide_store[store_addr(in_row, in_col)]  = it.guide;
      source_store[store_addr(in_row, in_col)] = it.source;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      complete = (in_row >= h);
    end
    if (out_pos >= total) out_pos = 0;
    y = out_pos / w;
    x = out_pos % w;
    received = complete ? total : in_row * w + in_col;
    need = ((y + r < h - 1) ? y + r : h - 1) * w + ((x + r < w - 1) ? x + r : w - 1);
    if (received <= need) return;
    res = filter_pixel(x, y, w, h, r);
    out_pos++;
    res.last = (out_pos == total);
    if (res.last) begin
      in_col = 0;
      in_row = 0;
      out_pos = 0;
    end
    owed_samples.push_back(res);
  endfunction

  // Input driver: offers the next pending item once the previous one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.kind          <= 1'b0;
      in_ch.guide_pixel   <= 8'd0;
      in_ch.source_sample <= 16'd0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        advance_filter(offered);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 14)) begin
        offered = pending_items.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= offered.kind;
        in_ch.guide_pixel   <= offered.guide;
        in_ch.source_sample <= offered.source;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Once, well into the run, the receiver refuses items for a long stretch
  // so that the core backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_done <= 1'b0;
      hold_left <= 0;
    end else if (!hold_done && accepted_cnt >= 100) begin
      hold_done <= 1'b1;
      hold_left <= 2500;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor: random back-pressure, the long hold, and the comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_samples.size() == 0) begin
          $display("%0t: unexpected output item sample=%h sat=%b last=%b", $time,
                   out_ch.filtered_sample, out_ch.saturated, out_ch.frame_last);
          errors++;
        end else begin
          want = owed_samples.pop_front();
          if (out_ch.filtered_sample !== want.sample) begin
            $display("%0t: filtered_sample expected %h actual %h", $time,
                     want.sample, out_ch.filtered_sample);
            errors++;
          end
          if (out_ch.saturated !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     want.sat, out_ch.saturated);
            errors++;
          end
          if (out_ch.frame_last !== want.last) begin
            $display("%0t: frame_last expected %b actual %b", $time,
                     want.last, out_ch.frame_last);
            errors++;
          end
          sample_cnt++;
          if (want.sat) sat_cnt++;
          if (want.last) frame_cnt++;
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  function automatic pixel_item_t make_pixel(pattern_e pat, int x, int y, int base);
    pixel_item_t it;
    it.kind = 1'b0;
    case (pat)
      PAT_FLAT: begin
        it.guide  = base[7:0];
        it.source = $urandom_range(65535);
      end
      PAT_NEAR_FLAT: begin
        it.guide  = base[7:0] + 8'($urandom_range(1));
        it.source = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      PAT_EXTREME: begin
        it.guide  = $urandom_range(1) ? 8'hFF : 8'h00;
        it.source = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      PAT_RAMP: begin
        it.guide  = 8'(x * 9 + y * 5 + $urandom_range(7));
        it.source = 16'(x * 2100 + y * 1300 + $urandom_range(4095));
      end
      default: begin
        it.guide  = $urandom_range(255);
        it.source = $urandom_range(65535);
      end
    endcase
    return it;
  endfunction

  function automatic pixel_item_t flush_tick();
    pixel_item_t it;
    it.kind   = 1'b1;
    it.guide  = $urandom_range(255);
    it.source = $urandom_range(65535);
    return it;
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [23:0] value);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    // The shadow follows the write that has just landed; any write restarts
    // the frame.
    case (idx)
      gif_pkg::REG_RADIUS: sh_radius = value[3:0];
      gif_pkg::REG_EPS:    sh_eps    = value;
      gif_pkg::REG_WIDTH:  sh_width  = value[10:0];
      gif_pkg::REG_HEIGHT: sh_height = value[10:0];
      default: ;
    endcase
    in_col = 0;
    in_row = 0;
    out_pos = 0;
  endtask

  task automatic set_filter(int unsigned r, int unsigned eps, int unsigned w,
                            int unsigned h);
    write_reg(gif_pkg::REG_RADIUS, 24'(r));
    write_reg(gif_pkg::REG_EPS, 24'(eps));
    write_reg(gif_pkg::REG_WIDTH, 24'(w));
    write_reg(gif_pkg::REG_HEIGHT, 24'(h));
  endtask

  // Waits until every item is taken and every owed result has come back,
  // then lets a no-result item still in flight finish.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || in_ch.valid || owed_samples.size() != 0);
    repeat (40) @(posedge clk_i);
  endtask

  // Queues a frame of pixels, with stray flush ticks mixed in. A full frame
  // is followed by enough drain items to empty the delay; some of them are
  // pixels that arrive after the frame input and act as flush ticks.
  task automatic queue_frame(int unsigned pixels, pattern_e pat, bit full,
                             output int unsigned queued);
    int unsigned w, r, base;
    w = used_width();
    r = used_radius(w);
    base = $urandom_range(254);
    queued = 0;
    for (int unsigned i = 0; i < pixels; i++) begin
      if ($urandom_range(99) < 8) begin
        pending_items.push_back(flush_tick());
        queued++;
      end
      pending_items.push_back(make_pixel(pat, i % w, i / w, base));
      queued++;
    end
    if (full) begin
      for (int unsigned i = 0; i < r * w + r + 3; i++) begin
        if ($urandom_range(99) < 30) begin
          pending_items.push_back(make_pixel(PAT_RANDOM, 0, 0, base));
        end else begin
          pending_items.push_back(flush_tick());
        end
        queued++;
      end
    end
  endtask

  initial begin
    pixel_item_t it;
    int unsigned queued, w, h;
    logic [7:0]  edge_guides  [4];
    logic [15:0] edge_sources [4];
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= gif_pkg::REG_RADIUS;
    cfg_ch.data  <= 24'd0;
    errors = 0;
    accepted_cnt = 0;
    sample_cnt = 0;
    sat_cnt = 0;
    frame_cnt = 0;
    calm = 1'b0;
    sh_radius = 4'd7;
    sh_eps = 24'd256;
    sh_width = 11'd640;
    sh_height = 11'd480;
    in_col = 0;
    in_row = 0;
    out_pos = 0;
    foreach (guide_store[i]) begin
      guide_store[i] = 8'd0;
      source_store[i] = 16'd0;
    end
    edge_guides  = '{8'h00, 8'hFF, 8'hAA, 8'h55};
    edge_sources = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    @(posedge rst_ni);

    // Directed opening: radius one, no regularizer, width and height
    // written as zero so both are clamped. The first items walk the field
    // extremes and include flush ticks before any output can be ready; the
    // rest of the frame keeps a flat guide so zero denominators appear.
    set_filter(1, 0, 0, 0);
    for (int i = 0; i < 16; i++) begin
      it.kind   = 1'b0;
      it.guide  = edge_guides[i % 4];
      it.source = edge_sources[i / 4];
      pending_items.push_back(it);
      if (i % 5 == 2) pending_items.push_back(flush_tick());
    end
    queue_frame(16 * 16 - 16, PAT_FLAT, 1'b1, queued);
    wait_drained();

    // Largest radius and largest regularizer, a partial frame only, since
    // every output costs a full 31 by 31 window.
    set_filter(15, 24'hFFFFFF, 16, 16);
    queue_frame(15 * 16 + 15 + 6, PAT_RAMP, 1'b0, queued);
    wait_drained();

    // Near-flat guide with no regularizer drives the slope up until the
    // output clamps at both ends; the first rows are enough.
    set_filter(2, 0, 16, 16);
    queue_frame(16 * 5, PAT_NEAR_FLAT, 1'b0, queued);
    wait_drained();

    // Widest and tallest register values, the width clamped by the core; only the
    // start of the first row is sent.
    set_filter(0, 256, 11'h7FF, 11'h7FF);
    queue_frame(40, PAT_RANDOM, 1'b0, queued);
    wait_drained();

    // Radius zero, odd frame size, and no idling on either side.
    calm = 1'b1;
    set_filter(0, 4096, 20, 17);
    queue_frame(20 * 3, PAT_EXTREME, 1'b0, queued);
    wait_drained();
    calm = 1'b0;

    // Random phases: mostly small radii and frame sizes with varied content.
    while (accepted_cnt < 750) begin
      w = $urandom_range(24, 16);
      h = $urandom_range(18, 16);
      case ($urandom_range(2))
        0: set_filter($urandom_range(4, 1), 0, w, h);
        1: set_filter($urandom_range(4, 1), $urandom_range(65535), w, h);
        default: set_filter($urandom_range(3, 1), $urandom_range(24'hFFFFFF), w, h);
      endcase
      if ($urandom_range(3) == 0) begin
        queue_frame($urandom_range(w * h - 1, w * 4), pattern_e'($urandom_range(4)),
                    1'b0, queued);
      end else begin
        queue_frame(w * h, pattern_e'($urandom_range(4)), 1'b1, queued);
      end
      wait_drained();
    end

    repeat (200) @(posedge clk_i);
    $display("Run covered %0d input items and %0d filtered items (%0d saturated).",
             accepted_cnt, sample_cnt, sat_cnt);
    $display("Frames completed: %0d; mismatches: %0d.", frame_cnt, errors);
    if (errors == 0 && owed_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/gif_pkg.sv
src/gif_if.sv
src/gif_ram.sv
src/gif_mul.sv
src/gif_div.sv
src/guided_image_filter_core.sv
bench/guided_image_filter_core_tb.sv
